// File: design/radix_string_to_magnitude_macros.svh
// ----------------------------------------------------------------------------
// Radix string to magnitude: assertion macros
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef RADIX_STRING_TO_MAGNITUDE_MACROS_SVH
`define RADIX_STRING_TO_MAGNITUDE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RSTM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RSTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rstm_pkg.sv
// ----------------------------------------------------------------------------
// Radix string to magnitude: package
// Sizes, status codes and shared types of the digit string converter.
// ----------------------------------------------------------------------------
package rstm_pkg;

  // Capacity of the magnitude store in bytes
  localparam int unsigned MAX_BYTES = 32;
  localparam int unsigned ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned LEN_W     = $clog2(MAX_BYTES + 1);

  // Radix register
  localparam int unsigned        RADIX_W     = 5;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;

  // Largest top byte that needs no sign guard byte in front
  localparam logic [7:0] TOP_BYTE_LIMIT = 8'd127;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // Classification of one character
  typedef struct packed {
    logic       blank;
    logic       digit;
    logic [3:0] value;
  } char_class_t;

  // Write port request into the magnitude store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage

// File: design/rstm_ram.sv
// ----------------------------------------------------------------------------
// Radix string to magnitude: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rstm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, one access of each per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/rstm_char_dec.sv
// ----------------------------------------------------------------------------
// Radix string to magnitude: character decoder
// Sorts an ASCII code into whitespace, hex digit with its value, or other.
// ----------------------------------------------------------------------------
module rstm_char_dec import rstm_pkg::*; (
  input  logic [7:0]  char_code_i,
  output char_class_t class_o
);

  // Classify whitespace and digit ranges
  always_comb begin
    class_o.blank = (char_code_i == 8'd32) ||
                    ((char_code_i >= 8'd9) && (char_code_i <= 8'd13));
    class_o.digit = 1'b0;
    class_o.value = 4'd0;
    if ((char_code_i >= 8'd48) && (char_code_i <= 8'd57)) begin
      class_o.digit = 1'b1;
      class_o.value = 4'(char_code_i - 8'd48);
    end else if ((char_code_i >= 8'd65) && (char_code_i <= 8'd70)) begin
      class_o.digit = 1'b1;
      class_o.value = 4'(char_code_i - 8'd55);
    end else if ((char_code_i >= 8'd97) && (char_code_i <= 8'd102)) begin
      class_o.digit = 1'b1;
      class_o.value = 4'(char_code_i - 8'd87);
    end
  end

endmodule

// File: design/rstm_seq.sv
// ----------------------------------------------------------------------------
// Radix string to magnitude: sequencer
// Runs the multiply-accumulate pass over the stored bytes for each digit and
// reads the value back out, most significant byte first, into the result
// register, with a zero guard byte where needed, or one fault or zero result.
// ----------------------------------------------------------------------------
module rstm_seq import rstm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Item channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               has_char_i,
  input  logic               end_of_string_i,
  input  char_class_t        chr_i,
  input  logic [RADIX_W-1:0] base_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         status_o,
  output logic               last_byte_o,
  // Magnitude store
  output ram_wr_t            ram_wr_o,
  output logic [ADDR_W-1:0]  ram_raddr_o,
  input  logic [7:0]         ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_APPEND,
    S_EMIT,
    S_TOP,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [1:0]        fault_q, fault_d;
  logic [3:0]        carry_q, carry_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              end_q, end_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [1:0]        status_q, status_d;
  logic              last_q, last_d;

  logic              take;
  logic              bad_digit;
  logic              out_free;
  logic [11:0]       mac_sum;
  logic [LEN_W-1:0]  len_m1;

  // Digit qualification
  assign take      = has_char_i && (fault_q == ST_OK) && !chr_i.blank;
  assign bad_digit = !chr_i.digit || ({1'b0, chr_i.value} >= base_i);
  assign out_free  = !out_valid_q || !out_stall_i;

  // One byte step: stored byte times radix plus incoming carry
  assign mac_sum = 12'({4'b0, ram_rdata_i} * {7'b0, base_i}) + 12'(carry_q);
  assign len_m1  = len_q - LEN_W'(1);

  // Next state, store access and result loading
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    fault_d     = fault_q;
    carry_d     = carry_q;
    idx_d       = idx_q;
    end_d       = end_q;
    out_byte_d  = out_byte_q;
    status_d    = status_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_wr_o    = '0;
    ram_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          end_d = end_of_string_i;
          if (take && bad_digit) begin
            fault_d = ST_BAD_DIGIT;
            state_d = end_of_string_i ? S_EMIT : S_IDLE;
          end else if (take) begin
            carry_d = chr_i.value;
            idx_d   = '0;
            state_d = (len_q == '0) ? S_APPEND : S_MAC;
          end else begin
            state_d = end_of_string_i ? S_EMIT : S_IDLE;
          end
        end
      end

      S_MAC: begin
        // Write back this byte while the next one is read
        ram_raddr_o = idx_q + ADDR_W'(1);
        ram_wr_o    = '{en: 1'b1, addr: idx_q, data: mac_sum[7:0]};
        carry_d     = mac_sum[11:8];
        idx_d       = idx_q + ADDR_W'(1);
        if ((LEN_W'(idx_q) + LEN_W'(1)) == len_q) begin
          state_d = S_APPEND;
        end
      end

      S_APPEND: begin
        // Grow the value by one byte, or flag overflow when it is full
        if (carry_q != 4'd0) begin
          if (len_q == LEN_W'(MAX_BYTES)) begin
            fault_d = ST_OVERFLOW;
          end else begin
            ram_wr_o = '{en: 1'b1, addr: len_q[ADDR_W-1:0], data: {4'b0, carry_q}};
            len_d    = len_q + LEN_W'(1);
          end
        end
        state_d = end_q ? S_EMIT : S_IDLE;
      end

      S_EMIT: begin
        ram_raddr_o = len_m1[ADDR_W-1:0];
        idx_d       = len_m1[ADDR_W-1:0];
        if ((fault_q != ST_OK) || (len_q == '0)) begin
          // Single result: fault code, or a zero value
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = 8'h00;
            status_d    = fault_q;
            last_d      = 1'b1;
            len_d       = '0;
            fault_d     = ST_OK;
            state_d     = S_IDLE;
          end
        end else begin
          state_d = S_TOP;
        end
      end

      S_TOP: begin
        // Put a zero byte in front of a top byte with its high bit set
        ram_raddr_o = idx_q;
        if (ram_rdata_i > TOP_BYTE_LIMIT) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = 8'h00;
            status_d    = ST_OK;
            last_d      = 1'b0;
            state_d     = S_OUT;
          end
        end else begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        // Hand out one byte per transaction, reading the next one below
        ram_raddr_o = idx_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = ram_rdata_i;
          status_d    = ST_OK;
          last_d      = (idx_q == '0);
          ram_raddr_o = idx_q - ADDR_W'(1);
          idx_d       = idx_q - ADDR_W'(1);
          if (idx_q == '0) begin
            len_d   = '0;
            fault_d = ST_OK;
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      fault_q     <= ST_OK;
      out_valid_q <= 1'b0;
      carry_q     <= '0;
      idx_q       <= '0;
      end_q       <= 1'b0;
      out_byte_q  <= '0;
      status_q    <= ST_OK;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
      carry_q     <= carry_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      out_byte_q  <= out_byte_d;
      status_q    <= status_d;
      last_q      <= last_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;
  assign last_byte_o = last_q;

endmodule

// File: design/radix_string_to_magnitude.sv
// ----------------------------------------------------------------------------
// Radix string to magnitude: top level
// A digit item runs the one-byte-per-cycle multiply-accumulate pass through
// the magnitude RAM, then an append step; a skipped character or an item
// with no end and no digit does not stall the input. An end item, after its
// digit pass if it has one, loads a fault or zero result in S_EMIT, or a
// guard byte where needed in S_TOP, then one byte per cycle from S_OUT while
// the result side does not stall; input stalls until the last byte is loaded.
// Reset: radix 16, empty value, no fault; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module radix_string_to_magnitude import rstm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Radix register write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RADIX_W-1:0] cfg_radix_i,
  // Character items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               has_char_i,
  input  logic               end_of_string_i,
  // Magnitude bytes
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         status_o,
  output logic               last_byte_o
);

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] base;
  char_class_t        chr;
  ram_wr_t            ram_wr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  // Radix register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_radix_i;
    end
  end

  // Clamp the radix into its legal range
  always_comb begin
    priority if (radix_q < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_q;
    end
  end

  rstm_char_dec u_char_dec (
    .char_code_i (char_code_i),
    .class_o     (chr)
  );

  rstm_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .has_char_i      (has_char_i),
    .end_of_string_i (end_of_string_i),
    .chr_i           (chr),
    .base_i          (base),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .status_o        (status_o),
    .last_byte_o     (last_byte_o),
    .ram_wr_o        (ram_wr),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  rstm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_mag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: design/rstm_checker.sv
// ----------------------------------------------------------------------------
// Radix string to magnitude: port checker
// Watches the top level's ports and flags broken result or busy behaviour.
// ----------------------------------------------------------------------------
`include "radix_string_to_magnitude_macros.svh"

module rstm_checker import rstm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               end_of_string_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [7:0]         out_byte_o,
  input logic [1:0]         status_o,
  input logic               last_byte_o
);

  // Hold a stalled result transaction unchanged
  `RSTM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(status_o) && $stable(last_byte_o), "stalled result changed")

  // A fault result is a single zero byte that closes the run
  `RSTM_ASSERT_IMPLY(a_fault_single, out_valid_o && (status_o != ST_OK), last_byte_o && (out_byte_o == 8'h00), "fault result not a single closing zero byte")

  // Stall input after an end transaction while the run is read out
  `RSTM_ASSERT_NEXT(a_end_busy, in_valid_i && !in_stall_o && end_of_string_i, in_stall_o, "input taken straight after end of string")

  // Stay busy while a byte other than the last of the run is offered
  `RSTM_ASSERT_IMPLY(a_mid_run_busy, out_valid_o && !last_byte_o, in_stall_o, "input taken in the middle of a byte run")

endmodule

bind radix_string_to_magnitude rstm_checker u_rstm_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix string to magnitude: testbench
// Feeds digit strings in a range of bases, including blanks, bad digits,
// empty strings and values at and beyond the store capacity. A local model
// predicts the big-endian bytes of each string, and a monitor compares every
// result byte with the oldest prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
  import rstm_pkg::*;

  // Whitespace characters the block skips
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam int unsigned NOT_DIGIT    = 16;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } mag_byte_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [RADIX_W-1:0] cfg_radix_i     = RADIX_RESET;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_i     = 8'd0;
  logic               has_char_i      = 1'b0;
  logic               end_of_string_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [7:0]         out_byte_o;
  logic [1:0]         status_o;
  logic               last_byte_o;

  // Local copy of the converter state
  logic [7:0]         acc_bytes [MAX_BYTES];
  int unsigned        acc_len       = 0;
  logic [1:0]         acc_fault     = ST_OK;
  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
  mag_byte_t          expected_bytes [$];

  int unsigned error_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          idling_en    = 1'b1;

  radix_string_to_magnitude dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_radix_i    (cfg_radix_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .has_char_i     (has_char_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .status_o       (status_o),
    .last_byte_o    (last_byte_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[radix_string_to_magnitude] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int unsigned digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return NOT_DIGIT;
  endfunction

  function automatic int unsigned active_base();
    if (radix_setting < RADIX_MIN) return RADIX_MIN;
    if (radix_setting > RADIX_MAX) return RADIX_MAX;
    return radix_setting;
  endfunction

  // Multiply the held value by the base and add one digit, little-endian
  function automatic void magnitude_mac(input int unsigned base, input int unsigned digit);
    int unsigned carry;
    int unsigned t;
    carry = digit;
    for (int unsigned i = 0; i < acc_len; i++) begin
      t = acc_bytes[i] * base + carry;
      acc_bytes[i] = t[7:0];
      carry = t >> 8;
    end
    while (carry != 0) begin
      if (acc_len >= MAX_BYTES) begin
        acc_fault = ST_OVERFLOW;
        return;
      end
      acc_bytes[acc_len] = carry[7:0];
      acc_len++;
      carry = carry >> 8;
    end
  endfunction

  // Advance the model by one accepted transaction and queue its result bytes
  function automatic void convert_char(input logic [7:0] c, input logic has,
                                       input logic eos);
    int unsigned base;
    int unsigned d;
    mag_byte_t   r;
    base = active_base();
    if (has && acc_fault == ST_OK && !is_blank(c)) begin
      d = digit_of(c);
      if (d >= base) acc_fault = ST_BAD_DIGIT;
      else magnitude_mac(base, d);
    end
    if (!eos) return;
    if (acc_fault != ST_OK) begin
      r = '{value: 8'h00, status: acc_fault, last: 1'b1};
      expected_bytes.push_back(r);
    end else begin
      // Guard byte keeps the top bit clear; an empty value gives one zero byte
      if (acc_len == 0 || acc_bytes[acc_len-1] > TOP_BYTE_LIMIT) begin
        r = '{value: 8'h00, status: ST_OK, last: 1'b0};
        expected_bytes.push_back(r);
      end
      for (int unsigned i = acc_len; i > 0; i--) begin
        r = '{value: acc_bytes[i-1], status: ST_OK, last: 1'b0};
        expected_bytes.push_back(r);
      end
      expected_bytes[expected_bytes.size()-1].last = 1'b1;
    end
    acc_len   = 0;
    acc_fault = ST_OK;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    mag_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h status %0d last %0b",
                                  out_byte_o, status_o, last_byte_o));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.value || status_o !== want.status ||
            last_byte_o !== want.last)
          report_mismatch($sformatf("got byte %02h status %0d last %0b, want %02h %0d %0b",
                                    out_byte_o, status_o, last_byte_o,
                                    want.value, want.status, want.last));
      end
    end
  end

  // Result side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (idling_en && stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idling_en && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 16);
      out_stall_i <= 1'b1;
    end else begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- drivers

  // Offer one character transaction, hold it while stalled, then predict
  task automatic send_char(input logic [7:0] c, input logic has, input logic eos);
    if (idling_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    char_code_i     <= c;
    has_char_i      <= has;
    end_of_string_i <= eos;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    convert_char(c, has, eos);
    if (has || eos) items_sent++;
  endtask

  // Send a whole string, the last character closing it; an empty string sends an end-only transaction
  task automatic send_text(input string s);
    if (s.len() == 0) begin
      send_char(8'd0, 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], 1'b1, i == s.len() - 1);
  endtask

  // Send one character n times, then close with an end-only transaction
  task automatic send_digits(input logic [7:0] c, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_char(c, 1'b1, 1'b0);
    send_char(8'($urandom), 1'b0, 1'b1);
  endtask

  // Hold the input idle until every expected byte has come, then let it settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] value);
    wait_idle();
    cfg_radix_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    radix_setting = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return 8'(v) + "0";
    if ($urandom_range(0, 1) == 0) return 8'(v - 10) + "A";
    return 8'(v - 10) + "a";
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom); while (digit_of(c) != NOT_DIGIT || is_blank(c));
    return c;
  endfunction

  // One random string: mostly well-formed, some noise, broken and empty runs
  task automatic send_random_run(input int unsigned base);
    int unsigned kind;
    int unsigned n;
    int unsigned ending;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      n      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      ending = $urandom_range(0, 2);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0) send_char(blank_char(), 1'b1, 1'b0);
        if ($urandom_range(0, 9) == 0) send_char(8'($urandom), 1'b0, 1'b0);
        send_char(digit_char($urandom_range(0, base - 1)), 1'b1,
                  ending == 0 && i == n - 1);
      end
      if (ending == 1) send_char(8'($urandom), 1'b0, 1'b1);
      if (ending == 2) send_char(blank_char(), 1'b1, 1'b1);
    end else if (kind == 7) begin
      n = $urandom_range(1, 8);
      for (int unsigned i = 0; i < n; i++)
        send_char(8'($urandom), 1'($urandom_range(0, 1)), i == n - 1);
    end else if (kind == 8) begin
      n = $urandom_range(0, 6);
      for (int unsigned i = 0; i < n; i++)
        send_char(digit_char($urandom_range(0, base - 1)), 1'b1, 1'b0);
      if (base < RADIX_MAX && $urandom_range(0, 1) == 0)
        send_char(digit_char($urandom_range(base, 15)), 1'b1, 1'b0);
      else
        send_char(junk_char(), 1'b1, 1'b0);
      n = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n; i++) send_char(8'($urandom), 1'b1, 1'b0);
      send_char(8'($urandom), 1'b0, 1'b1);
    end else begin
      if ($urandom_range(0, 1) == 0) send_char(blank_char(), 1'b1, 1'b0);
      send_char(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // ------------------------------------------------------------------ tests

  // Empty strings and zero values give the single byte 0x00
  task automatic test_empty_and_zero();
    send_char(8'hff, 1'b0, 1'b1);
    send_text("0");
    send_text("000");
  endtask

  // Guard byte in front of a top byte above 127
  task automatic test_sign_guard();
    send_text("7f");
    send_text("80");
    send_text("FFff");
  endtask

  // Every blank is skipped, an item with no character and no end does nothing
  task automatic test_blanks_and_null();
    send_char(CH_SPACE, 1'b1, 1'b0);
    send_char("1", 1'b1, 1'b0);
    send_char(CH_TAB, 1'b1, 1'b0);
    send_char(CH_LF, 1'b1, 1'b0);
    send_char("2", 1'b1, 1'b0);
    send_char("z", 1'b0, 1'b0);
    send_char(CH_VT, 1'b1, 1'b0);
    send_char(CH_FF, 1'b1, 1'b0);
    send_char("3", 1'b1, 1'b0);
    send_char(CH_CR, 1'b1, 1'b1);
  endtask

  task automatic test_digit_case();
    send_text("09AFaf");
    send_text("BcDe");
  endtask

  // First fault is kept and later characters are ignored
  task automatic test_invalid_digit();
    send_text("1g2");
    send_char(8'h00, 1'b1, 1'b1);
    send_char(8'hff, 1'b1, 1'b0);
    send_char("z", 1'b1, 1'b0);
    send_char("5", 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b1);
  endtask

  // Both ends of the base range, and settings outside it
  task automatic test_radix_range();
    write_radix(RADIX_MIN);
    send_text("101");
    send_text("12");
    write_radix(5'd10);
    send_text("255");
    send_text("9a");
    write_radix(5'd0);
    send_text("1101");
    send_text("2");
    write_radix(5'd1);
    send_text("1");
    write_radix(5'd17);
    send_text("g");
    send_text("fe");
    write_radix(5'd31);
    send_text("ff");
    write_radix(5'd8);
    send_text("777");
    send_text("8");
    write_radix(RADIX_MAX);
  endtask

  // A value that fills the store exactly and then needs one byte more
  task automatic test_capacity();
    send_digits("f", 2 * MAX_BYTES + 1);
  endtask

  task automatic test_random_strings();
    logic [RADIX_W-1:0] plan [8] = '{RADIX_MIN, RADIX_MAX, 5'd10, 5'd0,
                                     5'd31, 5'd8, 5'd1, 5'd17};
    int unsigned start;
    int unsigned phase;
    start = items_sent;
    phase = 0;
    while (items_sent - start < 16) begin
      write_radix(phase < 8 ? plan[phase] : 5'($urandom_range(0, 31)));
      idling_en = (phase % 4 != 3);
      begin
        int unsigned phase_start;
        phase_start = items_sent;
        while (items_sent - phase_start < 8) send_random_run(active_base());
      end
      phase++;
    end
    idling_en = 1'b1;
  endtask

  // Closing stretch with both sides always ready
  task automatic test_full_rate();
    idling_en = 1'b0;
    write_radix(5'($urandom_range(RADIX_MIN, RADIX_MAX)));
    for (int i = 0; i < 2; i++) send_random_run(active_base());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_zero();
    test_sign_guard();
    test_blanks_and_null();
    test_digit_case();
    test_invalid_digit();
    test_radix_range();
    test_capacity();
    test_random_strings();
    test_full_rate();
    wait_idle();
    if (error_count == 0) $display("[radix_string_to_magnitude] OK");
    else $display("[radix_string_to_magnitude] ERROR");
    $finish;
  end

endmodule

// File: radix_string_to_magnitude.f
+incdir+design
design/rstm_pkg.sv
design/rstm_ram.sv
design/rstm_char_dec.sv
design/rstm_seq.sv
design/radix_string_to_magnitude.sv
design/rstm_checker.sv
verif/testbench.sv
